@@ rtl/shmc_pkg.sv @@
// Package for the sliding Hamming match counter: sizes, codes, payload and command types.
// Used by every module in rtl/. Depends on nothing.
package shmc_pkg;

    localparam int MAX_PATTERN   = 64;
    localparam int ALPHABET_SIZE = 256;

    localparam int SYM_W  = 8;
    localparam int IDX_W  = $clog2(MAX_PATTERN);
    localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
    localparam int POS_W  = 32;
    localparam int FUNC_W = 2;
    localparam int WIN_W  = MAX_PATTERN * SYM_W;
    localparam int SHIFT_W = $clog2(WIN_W);

    // popcount tree: groups of eight match bits per partial sum
    localparam int POP_GRP  = 8;
    localparam int POP_NGRP = (MAX_PATTERN + POP_GRP - 1) / POP_GRP;
    localparam int POP_PADW = POP_NGRP * POP_GRP;
    localparam int PART_W   = $clog2(POP_GRP + 1);

    // command queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // APB register map
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam logic [0:0] REG_PATTERN_LENGTH = 1'b0;

    localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TEXT    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_TEXT,
        OP_RESTART
    } op_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [SYM_W-1:0]  symbol;
        logic [IDX_W-1:0]  pattern_index;
    } in_t;

    typedef struct packed {
        logic [POS_W-1:0] alignment_position;
        logic [LEN_W-1:0] match_count;
        logic [LEN_W-1:0] mismatch_count;
    } out_t;

    typedef struct packed {
        op_t              op;
        logic [SYM_W-1:0] symbol;
        logic [IDX_W-1:0] index;
    } cmd_t;

    function automatic logic [SYM_W-1:0] clamp_symbol(input logic [SYM_W-1:0] sym);
        logic [SYM_W-1:0] top;
        top = SYM_W'(ALPHABET_SIZE - 1);
        return (sym > top) ? top : sym;
    endfunction

    // one bit per pattern position below len
    function automatic logic [MAX_PATTERN-1:0] len_mask(input logic [LEN_W-1:0] len);
        logic [MAX_PATTERN-1:0] m;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            m[i] = (LEN_W'(i) < len);
        end
        return m;
    endfunction

endpackage

@@ rtl/shmc_front.sv @@
// Front end of the sliding Hamming match counter: decodes input beats into commands
// and holds them in a short queue for the back end. Depends on shmc_pkg.
module shmc_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  shmc_pkg::in_t     s_data,
    output logic              q_valid,
    output shmc_pkg::cmd_t    q_cmd,
    input  logic              q_pop
);

    shmc_pkg::cmd_t cmd;
    logic           keep;
    logic           push;

    shmc_pkg::cmd_t                  slot_mem [shmc_pkg::QDEPTH];
    logic [shmc_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [shmc_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [shmc_pkg::QCNT_W-1:0]     count_reg, count_next;

    // decode func; drop unused codes here
    always_comb begin
        cmd.symbol = shmc_pkg::clamp_symbol(s_data.symbol);
        cmd.index  = s_data.pattern_index;
        cmd.op     = shmc_pkg::OP_LOAD;
        keep       = 1'b1;
        case (s_data.func)
            shmc_pkg::FUNC_LOAD:    cmd.op = shmc_pkg::OP_LOAD;
            shmc_pkg::FUNC_TEXT:    cmd.op = shmc_pkg::OP_TEXT;
            shmc_pkg::FUNC_RESTART: cmd.op = shmc_pkg::OP_RESTART;
            default:                keep = 1'b0;
        endcase
    end

    assign s_ready = (count_reg != shmc_pkg::QCNT_W'(shmc_pkg::QDEPTH));
    assign push    = s_valid && s_ready && keep;
    assign q_valid = (count_reg != '0);
    assign q_cmd   = slot_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push  ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && q_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_mem[wr_ptr_reg] <= cmd;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= shmc_pkg::QCNT_W'(shmc_pkg::QDEPTH))
        else $error("queue count above depth");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

    a_full_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (!s_ready && !q_pop) |=> !s_ready)
        else $error("full queue freed without a pop");

endmodule

@@ rtl/shmc_back.sv @@
// Back end of the sliding Hamming match counter: pattern store, text window, compare,
// popcount tree and output register. Depends on shmc_pkg.
module shmc_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [shmc_pkg::LEN_W-1:0]  cfg_len,
    input  logic                        q_valid,
    input  shmc_pkg::cmd_t              q_cmd,
    output logic                        q_pop,
    output logic                        m_valid,
    input  logic                        m_ready,
    output shmc_pkg::out_t              m_data
);

    logic [shmc_pkg::LEN_W-1:0]   eff_len;
    logic [shmc_pkg::IDX_W-1:0]   shamt;
    logic [shmc_pkg::SHIFT_W-1:0] shift_bits;

    logic [shmc_pkg::SYM_W-1:0]   pat_reg [shmc_pkg::MAX_PATTERN];
    logic [shmc_pkg::WIN_W-1:0]   win_reg, win_next;
    logic [shmc_pkg::WIN_W-1:0]   aligned;
    logic [shmc_pkg::POS_W-1:0]   seen_reg, seen_next, seen_inc;

    logic                              s1_valid_reg, s1_valid_next;
    logic [shmc_pkg::MAX_PATTERN-1:0]  s1_match_reg, s1_match_next;
    logic [shmc_pkg::POS_W-1:0]        s1_pos_reg, s1_pos_next;
    logic [shmc_pkg::LEN_W-1:0]        s1_len_reg;

    logic                              s2_valid_reg;
    logic [shmc_pkg::PART_W-1:0]       s2_part_reg [shmc_pkg::POP_NGRP];
    logic [shmc_pkg::PART_W-1:0]       s2_part_next [shmc_pkg::POP_NGRP];
    logic [shmc_pkg::POS_W-1:0]        s2_pos_reg;
    logic [shmc_pkg::LEN_W-1:0]        s2_len_reg;
    logic [shmc_pkg::POP_PADW-1:0]     match_pad;

    logic                              m_valid_reg;
    shmc_pkg::out_t                    m_data_reg, m_data_next;
    logic [shmc_pkg::LEN_W-1:0]        total;

    logic out_free, s2_free, s1_free, is_text, hit;

    // clamp the register to the legal length range
    always_comb begin
        if (cfg_len == '0) begin
            eff_len = shmc_pkg::LEN_W'(1);
        end else if (cfg_len > shmc_pkg::LEN_W'(shmc_pkg::MAX_PATTERN)) begin
            eff_len = shmc_pkg::LEN_W'(shmc_pkg::MAX_PATTERN);
        end else begin
            eff_len = cfg_len;
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign q_pop    = q_valid && s1_free;
    assign is_text  = q_pop && (q_cmd.op == shmc_pkg::OP_TEXT);

    // newest symbol enters at the top entry, older ones move down
    assign win_next = {q_cmd.symbol, win_reg[shmc_pkg::WIN_W-1:shmc_pkg::SYM_W]};
    assign shamt    = shmc_pkg::IDX_W'(shmc_pkg::LEN_W'(shmc_pkg::MAX_PATTERN) - eff_len);
    assign shift_bits = shmc_pkg::SHIFT_W'(shamt) * shmc_pkg::SHIFT_W'(shmc_pkg::SYM_W);
    assign aligned  = win_next >> shift_bits;

    assign seen_inc = (seen_reg == '1) ? seen_reg : seen_reg + 1'b1;
    assign hit      = (seen_inc >= shmc_pkg::POS_W'(eff_len));

    always_comb begin
        seen_next = seen_reg;
        if (q_pop && q_cmd.op == shmc_pkg::OP_RESTART) begin
            seen_next = '0;
        end else if (is_text) begin
            seen_next = seen_inc;
        end
        s1_pos_next = seen_inc - shmc_pkg::POS_W'(eff_len);
        for (int i = 0; i < shmc_pkg::MAX_PATTERN; i++) begin
            s1_match_next[i] = (pat_reg[i] == aligned[i*shmc_pkg::SYM_W +: shmc_pkg::SYM_W]);
        end
        s1_match_next = s1_match_next & shmc_pkg::len_mask(eff_len);
        s1_valid_next = s1_valid_reg && !s2_free;
        if (is_text && hit) begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            seen_reg     <= seen_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (is_text) begin
            win_reg <= win_next;
        end
        if (q_pop && q_cmd.op == shmc_pkg::OP_LOAD) begin
            pat_reg[q_cmd.index] <= q_cmd.symbol;
        end
        if (is_text && hit) begin
            s1_match_reg <= s1_match_next;
            s1_pos_reg   <= s1_pos_next;
            s1_len_reg   <= eff_len;
        end
    end

    // popcount, first level: one partial per group of eight
    always_comb begin
        match_pad = shmc_pkg::POP_PADW'(s1_match_reg);
        for (int g = 0; g < shmc_pkg::POP_NGRP; g++) begin
            s2_part_next[g] = '0;
            for (int b = 0; b < shmc_pkg::POP_GRP; b++) begin
                s2_part_next[g] = s2_part_next[g]
                                + shmc_pkg::PART_W'(match_pad[g*shmc_pkg::POP_GRP + b]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_free) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_free && s1_valid_reg) begin
            s2_part_reg <= s2_part_next;
            s2_pos_reg  <= s1_pos_reg;
            s2_len_reg  <= s1_len_reg;
        end
    end

    // second level: add partials, derive the distance
    always_comb begin
        total = '0;
        for (int g = 0; g < shmc_pkg::POP_NGRP; g++) begin
            total = total + shmc_pkg::LEN_W'(s2_part_reg[g]);
        end
        m_data_next.alignment_position = s2_pos_reg;
        m_data_next.match_count        = total;
        m_data_next.mismatch_count     = s2_len_reg - total;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && s2_valid_reg) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_mask_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg |-> ((s1_match_reg & ~shmc_pkg::len_mask(s1_len_reg)) == '0))
        else $error("match bit beyond pattern length");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg |-> (s1_pos_reg <= ('1 - shmc_pkg::POS_W'(s1_len_reg))))
        else $error("alignment position out of range");

    a_s2_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s2_valid_reg && !out_free) |=> (s2_valid_reg && $stable(s2_pos_reg)))
        else $error("stalled popcount stage changed");

    a_count_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_free && s2_valid_reg) |=>
            ((m_data_reg.match_count + m_data_reg.mismatch_count) == $past(s2_len_reg)))
        else $error("match and mismatch do not add up to length");

endmodule

@@ rtl/sliding_hamming_match_count_unit.sv @@
// Top level of the sliding Hamming match counter: APB length register, front and back.
// Depends on shmc_pkg, shmc_front and shmc_back.
//
// Usage: load pattern symbols with func 0 (symbol at pattern_index), start a text with
// func 2, then stream text symbols with func 1. Once pattern_length text symbols have
// arrived since the last restart, every text beat yields one result beat on m_: the
// alignment start, the match count and the mismatch (Hamming) count. Func 3 is dropped.
// Set pattern_length (byte address 0) over APB only while the block is idle.
//
// Throughput: one input beat per cycle, sustained, for any mix of commands, while m_ready drains the output.
// Path: a text beat waits in the command queue, then passes the compare stage, the
// popcount stage and the output register, in that order, before m_valid rises. The
// popcount tree over the compare vector sets the stage count.
// Reset (aresetn low, synchronous) empties the queue and pipeline, clears the text
// position and sets pattern_length to 64; pattern contents are kept undefined until
// loaded. When m_ready is low the output register holds its beat, the pipeline stages
// fill up, then the four-entry command queue, and only then does s_ready drop.
module sliding_hamming_match_count_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  shmc_pkg::in_t                 s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output shmc_pkg::out_t                m_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [shmc_pkg::PADDR_W-1:0]  paddr,
    input  logic [shmc_pkg::PDATA_W-1:0]  pwdata,
    output logic [shmc_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    logic [shmc_pkg::LEN_W-1:0] len_reg, len_next;
    logic                       reg_wr;
    logic                       q_valid, q_pop;
    shmc_pkg::cmd_t             q_cmd;

    // APB: zero wait states; write lands in the access phase
    assign pready = 1'b1;
    assign reg_wr = psel && penable && pwrite && pready
                 && (paddr[2] == shmc_pkg::REG_PATTERN_LENGTH);

    always_comb begin
        len_next = len_reg;
        if (reg_wr) begin
            len_next = pwdata[shmc_pkg::LEN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= shmc_pkg::LEN_W'(shmc_pkg::MAX_PATTERN);
        end else begin
            len_reg <= len_next;
        end
    end

    // read back the raw register; other addresses read as zero
    always_comb begin
        prdata = '0;
        if (paddr[2] == shmc_pkg::REG_PATTERN_LENGTH) begin
            prdata = shmc_pkg::PDATA_W'(len_reg);
        end
    end

    // front: decode and queue the beats
    shmc_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop)
    );

    // back: pattern store, window, compare and count
    shmc_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg_len (len_reg),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
